// File: design/t2i_pkg.sv
package t2i_pkg;

  // Parse phases of one string
  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } t2i_phase_e;

  // Configuration register indexes
  localparam logic [7:0] CFG_NUMBER_BASE = 8'd0;
  localparam logic [7:0] CFG_SIGNED_MODE = 8'd1;

  localparam logic [5:0] BASE_RESET    = 6'd10;
  localparam logic [5:0] BASE_AUTO     = 6'd0;
  localparam logic [5:0] BASE_OCT      = 6'd8;
  localparam logic [5:0] BASE_DEC      = 6'd10;
  localparam logic [5:0] BASE_HEX      = 6'd16;
  localparam logic [5:0] BASE_MIN      = 6'd2;
  localparam logic [5:0] BASE_MAX      = 6'd36;
  localparam logic [5:0] DIGIT_INVALID = 6'd63;

  localparam logic [63:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN_M = 64'h8000_0000_0000_0000;
  localparam logic [63:0] U64_ALL   = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // Decoded character held in the input register
  typedef struct packed {
    logic       first;
    logic       space;
    logic       minus;
    logic       plus;
    logic       zero;
    logic       xchar;
    logic [5:0] dval;
  } t2i_item_t;

  // One result transaction
  typedef struct packed {
    logic [9:0]  end_offset;
    logic        parse_done;
    logic        range_error;
    logic        digits_seen;
    logic [63:0] parsed_value;
  } t2i_result_t;

  // Character to digit value, DIGIT_INVALID where it is no digit at all
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      v = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      v = c - CH_UP_A + 8'd10;
    end else begin
      v = {2'b00, DIGIT_INVALID};
    end
    return v[5:0];
  endfunction

endpackage

// File: design/t2i_in_stage.sv
module t2i_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          text_byte_i,
  input  logic                first_byte_i,
  input  logic                take_i,
  output logic                item_valid_o,
  output t2i_pkg::t2i_item_t  item_o
);
  import t2i_pkg::*;

  logic      valid_q, valid_d;
  t2i_item_t item_q, item_d;

  // Free when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_q || take_i;

  // Character classification ahead of the register
  always_comb begin
    item_d.first = first_byte_i;
    item_d.space = (text_byte_i == CH_SPACE) ||
                   (text_byte_i >= CH_TAB && text_byte_i <= CH_CR);
    item_d.minus = (text_byte_i == CH_MINUS);
    item_d.plus  = (text_byte_i == CH_PLUS);
    item_d.zero  = (text_byte_i == CH_ZERO);
    item_d.xchar = (text_byte_i == CH_LO_X) || (text_byte_i == CH_UP_X);
    item_d.dval  = digit_value(text_byte_i);
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: design/t2i_step_core.sv
module t2i_step_core #(
  parameter int unsigned OFFSET_LIMIT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  t2i_pkg::t2i_item_t   item_i,
  output logic                 take_o,
  input  logic [5:0]           number_base_i,
  input  logic                 signed_mode_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output t2i_pkg::t2i_result_t result_o
);
  import t2i_pkg::*;

  localparam int unsigned PosCap = (OFFSET_LIMIT - 1 < 1023) ? OFFSET_LIMIT - 1 : 1023;

  t2i_phase_e  phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [63:0] acc_q, acc_d;
  logic [5:0]  base_q, base_d;
  logic        ovf_q, ovf_d;
  logic        any_q, any_d;
  logic [9:0]  pos_q, pos_d;
  logic        pz_q, pz_d;

  logic        out_valid_q, out_valid_d;
  t2i_result_t res_q, res_d;

  logic        out_free;
  logic        do_take;
  logic [69:0] prod;
  logic [63:0] lim;

  assign out_free = !out_valid_q || out_ready_i;
  assign take_o   = item_valid_i && out_free;

  // Next state of the parse for the held byte
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    base_d  = base_q;
    ovf_d   = ovf_q;
    any_d   = any_q;
    pos_d   = pos_q;
    pz_d    = pz_q;
    do_take = 1'b0;
    prod    = '0;
    lim     = U64_ALL;

    // A new string clears everything and latches the base
    if (item_i.first) begin
      phase_d = PH_SPACE;
      neg_d   = 1'b0;
      acc_d   = '0;
      ovf_d   = 1'b0;
      any_d   = 1'b0;
      pos_d   = '0;
      pz_d    = 1'b0;
      base_d  = number_base_i;
    end

    if (phase_d != PH_DONE) begin
      unique case (phase_d)
        PH_SPACE, PH_SIGN: begin
          if (phase_d == PH_SPACE && item_i.space) begin
            // keep skipping
          end else if (phase_d == PH_SPACE && item_i.minus) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGN;
          end else if (phase_d == PH_SPACE && item_i.plus) begin
            phase_d = PH_SIGN;
          end else begin
            // First character of the number proper
            phase_d = PH_DIGITS;
            if ((base_d == BASE_AUTO || base_d == BASE_HEX) && item_i.zero) begin
              pz_d = 1'b1;
            end else begin
              if (base_d == BASE_AUTO) begin
                base_d = BASE_DEC;
              end
              do_take = 1'b1;
            end
          end
        end
        PH_DIGITS: begin
          if (pz_d) begin
            // Lookahead after a leading zero decides on the hex prefix
            pz_d = 1'b0;
            if (item_i.xchar) begin
              base_d = BASE_HEX;
            end else begin
              if (base_d == BASE_AUTO) begin
                base_d = BASE_OCT;
              end
              any_d   = 1'b1;
              do_take = 1'b1;
            end
          end else begin
            do_take = 1'b1;
          end
        end
        default: ;
      endcase

      // Digit accumulate with overflow check on the full product
      if (do_take) begin
        if (base_d < BASE_MIN || base_d > BASE_MAX || item_i.dval >= base_d) begin
          phase_d = PH_DONE;
        end else begin
          any_d = 1'b1;
          if (!ovf_d) begin
            if (signed_mode_i) begin
              lim = neg_d ? S64_MIN_M : S64_MAX;
            end
            prod = {6'd0, acc_d} * {64'd0, base_d} + {64'd0, item_i.dval};
            if (prod > {6'd0, lim}) begin
              ovf_d = 1'b1;
            end else begin
              acc_d = prod[63:0];
            end
          end
        end
      end

      if (phase_d != PH_DONE && pos_d < 10'(PosCap)) begin
        pos_d = pos_d + 10'd1;
      end
    end
  end

  // Result as seen after this byte
  always_comb begin
    if (signed_mode_i && ovf_d) begin
      res_d.parsed_value = neg_d ? S64_MIN_M : S64_MAX;
    end else if (ovf_d) begin
      res_d.parsed_value = U64_ALL;
    end else begin
      res_d.parsed_value = neg_d ? (64'd0 - acc_d) : acc_d;
    end
    res_d.digits_seen = any_d;
    res_d.range_error = ovf_d;
    res_d.parse_done  = (phase_d == PH_DONE);
    res_d.end_offset  = any_d ? pos_d : 10'd0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SPACE;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      base_q      <= BASE_RESET;
      ovf_q       <= 1'b0;
      any_q       <= 1'b0;
      pos_q       <= '0;
      pz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        base_q  <= base_d;
        ovf_q   <= ovf_d;
        any_q   <= any_d;
        pos_q   <= pos_d;
        pz_q    <= pz_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// File: design/text_to_integer_parser.sv
// Streaming text-to-integer parser, 64 bit, strtoll/strtoull rules.
// Input stream: one character per transaction in s_axis_tdata; s_axis_tuser
// set marks the first character of a new string and clears the parse.
// Output stream: one result per input transaction, giving the value as if
// the number ended after that character, plus digit, range-error and done
// flags and the end offset.
// Configuration: cfg_valid_i/cfg_ready_o write channel; index 0 is the base
// (0 selects by prefix), index 1 selects signed saturation. Write only while
// the block is idle; the base is latched at each first character.
// Path: input register, then result register. Throughput: one transaction
// per cycle while the receiver takes results; the only loop is the accumulate
// step, a 64 x 6 bit multiply-add and compare against the saturation limit.
// Reset: parse state cleared, base 10, signed mode, both streams empty.
// When the receiver stalls, the result register holds, the input register
// fills behind it and s_axis_tready then falls until the result is taken.
module text_to_integer_parser #(
  parameter int unsigned OFFSET_LIMIT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [63:0] parsed_value, [64] digits_seen,
                                      // [65] range_error, [66] parse_done,
                                      // [76:67] end_offset, [79:77] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import t2i_pkg::*;

  localparam int unsigned PosCap = (OFFSET_LIMIT - 1 < 1023) ? OFFSET_LIMIT - 1 : 1023;

  logic [5:0]  base_q, base_d;
  logic        signed_q, signed_d;
  logic        item_valid;
  t2i_item_t   item;
  logic        take;
  t2i_result_t result;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    base_d   = base_q;
    signed_d = signed_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUMBER_BASE: base_d   = cfg_data_i[5:0];
        CFG_SIGNED_MODE: signed_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_RESET;
      signed_q <= 1'b1;
    end else begin
      base_q   <= base_d;
      signed_q <= signed_d;
    end
  end

  t2i_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .text_byte_i  (s_axis_tdata),
    .first_byte_i (s_axis_tuser),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  t2i_step_core #(
    .OFFSET_LIMIT (OFFSET_LIMIT)
  ) u_step_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .take_o        (take),
    .number_base_i (base_q),
    .signed_mode_i (signed_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_o      (result)
  );

  assign m_axis_tdata = {3'b000, result};

  // No digits means no end offset
  a_offset_needs_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata[76:67] == 10'd0)
    else $error("end offset set without digits");

  // Overflow can only follow a taken digit
  a_range_needs_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[64])
    else $error("range error without digits");

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Offset stays within its cap
  a_offset_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[76:67] <= 10'(PosCap))
    else $error("end offset beyond cap");

endmodule
